>>> rtl/core/mh64_pkg.sv
`default_nettype none

package mh64_pkg;

  localparam int unsigned LEN_W       = 13;
  localparam int unsigned SEED_W      = 32;
  localparam int unsigned WORD_W      = 64;
  localparam int unsigned HALF_W      = 32;
  localparam int unsigned MIX_SHIFT   = 47;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [WORD_W-1:0] MIX_MUL       = 64'hc6a4a7935bd1e995;
  localparam logic [LEN_W-1:0]  MAX_KEY_BYTES = 13'd4096;

  // What the back end does with one queued word
  typedef enum logic [1:0] {
    OP_MIX,    // full word: mix, fold into hash
    OP_TAIL,   // partial final word, already masked
    OP_FINAL   // empty key: finalizer only
  } op_e;

  typedef struct packed {
    logic              start;     // first word: reload hash from seed
    logic [LEN_W-1:0]  init_len;  // saturated key length
    logic [WORD_W-1:0] data;
    op_e               op;
    logic              last;      // finalize after this word
  } entry_t;

endpackage

`default_nettype wire

>>> rtl/core/murmur_hash_64a.sv
// A multiply by the mix constant uses one 32x32 multiplier, a partial product per phase.
// A full middle word is dispatched from idle, then takes 3 multiplies (mix, mix, hash);
// a first word adds the seed/length multiply; a last word adds the finalizer and then
// loads the output when the output register is free; a tail word skips the mix multiplies.
// Empty keys only finalize; a 2-deep queue takes words while the back end works.
// Reset: asynchronous, active low; clears hash, length, seed and all valid state.
`default_nettype none

module murmur_hash_64a (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        first_word_i,
  input  logic [mh64_pkg::LEN_W-1:0]  key_length_i,
  input  logic [mh64_pkg::WORD_W-1:0] data_word_i,
  input  logic                        last_word_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [mh64_pkg::WORD_W-1:0] hash_value_o,
  input  logic                        cfg_we_i,
  input  logic [mh64_pkg::SEED_W-1:0] cfg_wdata_i
);
  import mh64_pkg::*;

  logic   push, full, pop, q_valid;
  entry_t push_entry, q_entry;

  mh64_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .first_word_i (first_word_i),
    .key_length_i (key_length_i),
    .data_word_i  (data_word_i),
    .last_word_i  (last_word_i),
    .full_i       (full),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  mh64_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (q_entry)
  );

  mh64_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .q_valid_i    (q_valid),
    .q_entry_i    (q_entry),
    .q_pop_o      (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hash_value_o (hash_value_o)
  );

endmodule

`default_nettype wire

>>> rtl/core/mh64_front.sv
`default_nettype none

module mh64_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     first_word_i,
  input  logic [mh64_pkg::LEN_W-1:0]  key_length_i,
  input  logic [mh64_pkg::WORD_W-1:0] data_word_i,
  input  logic                     last_word_i,
  input  logic                     full_i,
  output logic                     push_o,
  output mh64_pkg::entry_t         push_entry_o
);
  import mh64_pkg::*;

  logic [LEN_W-1:0]  len_q, len_d;
  logic [LEN_W-1:0]  sat_len;
  logic [LEN_W-1:0]  eff_len;
  logic [WORD_W-1:0] tail_mask;

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  assign sat_len = (key_length_i > MAX_KEY_BYTES) ? MAX_KEY_BYTES : key_length_i;
  assign eff_len = first_word_i ? sat_len : len_q;

  // keep only the low (length mod 8) bytes of a tail word
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      tail_mask[b*8 +: 8] = (3'(b) < eff_len[2:0]) ? 8'hff : 8'h00;
    end
  end

  always_comb begin
    push_entry_o.start    = first_word_i;
    push_entry_o.init_len = sat_len;
    push_entry_o.last     = last_word_i;
    push_entry_o.data     = data_word_i;
    push_entry_o.op       = OP_MIX;
    if (last_word_i) begin
      if (eff_len == '0) begin
        push_entry_o.op = OP_FINAL;
      end else if (eff_len[2:0] != 3'd0) begin
        push_entry_o.op   = OP_TAIL;
        push_entry_o.data = data_word_i & tail_mask;
      end
    end
  end

  assign len_d = (push_o && first_word_i) ? sat_len : len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else begin
      len_q <= len_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/mh64_fifo.sv
`default_nettype none

module mh64_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  mh64_pkg::entry_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output mh64_pkg::entry_t data_o
);
  import mh64_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  entry_t            mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == FULL_CNT);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/mh64_back.sv
`default_nettype none

module mh64_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mh64_pkg::SEED_W-1:0] cfg_wdata_i,
  input  logic                        q_valid_i,
  input  mh64_pkg::entry_t            q_entry_i,
  output logic                        q_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [mh64_pkg::WORD_W-1:0] hash_value_o
);
  import mh64_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_MIX1,
    ST_MIX2,
    ST_HMUL,
    ST_FMUL,
    ST_EMIT
  } state_e;

  typedef struct packed {
    state_e            st;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] h;
  } disp_t;

  state_e            state_q, state_d;
  logic [1:0]        phase_q, phase_d;
  logic [WORD_W-1:0] mul_a_q, mul_a_d;
  logic [WORD_W-1:0] prod_q, prod_d;
  logic [WORD_W-1:0] h_q, h_d;
  logic [SEED_W-1:0] seed_q, seed_d;
  entry_t            ent_q, ent_d;
  logic              out_vld_q, out_vld_d;
  logic [WORD_W-1:0] out_q, out_d;

  logic [HALF_W-1:0] mul_x, mul_y;
  logic [WORD_W-1:0] mul_p;
  logic [WORD_W-1:0] mul_res;
  logic              mul_state, mul_done;
  disp_t             disp;

  // route a word to the first operation it needs, given the hash so far
  function automatic disp_t dispatch(entry_t e, logic [WORD_W-1:0] hv);
    disp_t r;
    r.h = hv;
    case (e.op)
      OP_MIX: begin
        r.st = ST_MIX1;
        r.a  = e.data;
      end
      OP_TAIL: begin
        r.st = ST_HMUL;
        r.h  = hv ^ e.data;
        r.a  = hv ^ e.data;
      end
      default: begin
        r.st = ST_FMUL;
        r.a  = hv ^ (hv >> MIX_SHIFT);
      end
    endcase
    return r;
  endfunction

  // 64x64 low-half multiply by the mix constant, one 32x32 product per phase:
  // low*low, then the two cross terms folded into the upper half
  assign mul_x = (phase_q == 2'd1) ? mul_a_q[WORD_W-1:HALF_W] : mul_a_q[HALF_W-1:0];
  assign mul_y = (phase_q == 2'd2) ? MIX_MUL[WORD_W-1:HALF_W] : MIX_MUL[HALF_W-1:0];
  assign mul_p = WORD_W'(mul_x) * WORD_W'(mul_y);
  assign mul_res = {prod_q[WORD_W-1:HALF_W] + mul_p[HALF_W-1:0], prod_q[HALF_W-1:0]};

  assign mul_state = (state_q == ST_INIT) || (state_q == ST_MIX1) || (state_q == ST_MIX2)
                  || (state_q == ST_HMUL) || (state_q == ST_FMUL);
  assign mul_done  = mul_state && (phase_q == 2'd2);

  assign q_pop_o      = (state_q == ST_IDLE) && q_valid_i;
  assign out_valid_o  = out_vld_q;
  assign hash_value_o = out_q;

  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    mul_a_d   = mul_a_q;
    prod_d    = prod_q;
    h_d       = h_q;
    ent_d     = ent_q;
    out_vld_d = out_vld_q;
    out_d     = out_q;
    seed_d    = cfg_we_i ? cfg_wdata_i : seed_q;
    disp      = dispatch(ent_q, h_q ^ mul_res);

    if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end

    if (mul_state) begin
      if (phase_q == 2'd0) begin
        prod_d = mul_p;
      end else begin
        prod_d = mul_res;
      end
      phase_d = mul_done ? 2'd0 : phase_q + 2'd1;
    end

    case (state_q)
      ST_IDLE: begin
        phase_d = 2'd0;
        if (q_valid_i) begin
          ent_d = q_entry_i;
          if (q_entry_i.start) begin
            h_d     = {{(WORD_W-SEED_W){1'b0}}, seed_q};
            mul_a_d = {{(WORD_W-LEN_W){1'b0}}, q_entry_i.init_len};
            state_d = ST_INIT;
          end else begin
            disp    = dispatch(q_entry_i, h_q);
            h_d     = disp.h;
            mul_a_d = disp.a;
            state_d = disp.st;
          end
        end
      end
      ST_INIT: begin
        if (mul_done) begin
          h_d     = disp.h;
          mul_a_d = disp.a;
          state_d = disp.st;
        end
      end
      ST_MIX1: begin
        if (mul_done) begin
          mul_a_d = mul_res ^ (mul_res >> MIX_SHIFT);
          state_d = ST_MIX2;
        end
      end
      ST_MIX2: begin
        if (mul_done) begin
          h_d     = h_q ^ mul_res;
          mul_a_d = h_q ^ mul_res;
          state_d = ST_HMUL;
        end
      end
      ST_HMUL: begin
        if (mul_done) begin
          h_d = mul_res;
          if (ent_q.last) begin
            mul_a_d = mul_res ^ (mul_res >> MIX_SHIFT);
            state_d = ST_FMUL;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_FMUL: begin
        if (mul_done) begin
          h_d     = mul_res ^ (mul_res >> MIX_SHIFT);
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // hold until the output register is free
        if (!out_vld_q || !out_stall_i) begin
          out_d     = h_q;
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      phase_q   <= 2'd0;
      mul_a_q   <= '0;
      prod_q    <= '0;
      h_q       <= '0;
      seed_q    <= '0;
      ent_q     <= '0;
      out_vld_q <= 1'b0;
      out_q     <= '0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      mul_a_q   <= mul_a_d;
      prod_q    <= prod_d;
      h_q       <= h_d;
      seed_q    <= seed_d;
      ent_q     <= ent_d;
      out_vld_q <= out_vld_d;
      out_q     <= out_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/mh64_checker.sv
`default_nettype none

module mh64_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        last_word_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [mh64_pkg::WORD_W-1:0] hash_value_o
);

  // words marked last that have not yet produced a delivered hash
  logic [3:0] pending_q, pending_d;
  logic       in_last_acc, out_acc;

  assign in_last_acc = in_valid_i && !in_stall_o && last_word_i;
  assign out_acc     = out_valid_o && !out_stall_i;

  always_comb begin
    pending_d = pending_q;
    if (in_last_acc && !out_acc) begin
      pending_d = pending_q + 4'd1;
    end else if (!in_last_acc && out_acc) begin
      pending_d = pending_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  a_no_out_in_reset: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(hash_value_o))
    else $error("stalled hash dropped or changed");

  a_out_has_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 4'd0)
    else $error("hash shown without a finished key");

  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 4'd4)
    else $error("more keys in flight than the queue and back end hold");

endmodule

bind murmur_hash_64a mh64_checker u_mh64_checker (.*);

`default_nettype wire

>>> tb/sv/mh64_tb_pkg.sv
package mh64_tb_pkg;

  import mh64_pkg::*;

  class hash_board;
    logic [SEED_W-1:0] seed;
    logic [WORD_W-1:0] acc;
    logic [LEN_W-1:0]  held;
    logic [WORD_W-1:0] hashes_due[$];
    int unsigned       mismatches;

    function new();
      seed       = '0;
      acc        = '0;
      held       = '0;
      mismatches = 0;
    endfunction

    function void set_seed(logic [SEED_W-1:0] value);
      seed = value;
    endfunction

    function logic [WORD_W-1:0] mix(logic [WORD_W-1:0] k);
      k = k * MIX_MUL;
      k = k ^ (k >> MIX_SHIFT);
      k = k * MIX_MUL;
      return k;
    endfunction

    // Fold one accepted word into the running hash; queue the hash on a last word.
    function void note_word(logic first, logic [LEN_W-1:0] len, logic [WORD_W-1:0] data,
                            logic last);
      logic [WORD_W-1:0] h;
      logic [WORD_W-1:0] mask;
      logic [LEN_W-1:0]  n;
      logic [2:0]        tail;
      if (first) begin
        n    = (len > MAX_KEY_BYTES) ? MAX_KEY_BYTES : len;
        held = n;
        acc  = {{(WORD_W-SEED_W){1'b0}}, seed} ^ (WORD_W'(n) * MIX_MUL);
      end
      h    = acc;
      tail = held[2:0];
      if (!last) begin
        acc = (h ^ mix(data)) * MIX_MUL;
        return;
      end
      // empty key: skip the word, finalize only
      if (held != '0) begin
        if (tail == 3'd0) begin
          h = (h ^ mix(data)) * MIX_MUL;
        end else begin
          mask = (64'd1 << (8 * tail)) - 64'd1;
          h    = (h ^ (data & mask)) * MIX_MUL;
        end
      end
      h = h ^ (h >> MIX_SHIFT);
      h = h * MIX_MUL;
      h = h ^ (h >> MIX_SHIFT);
      acc = h;
      hashes_due.push_back(h);
    endfunction

    task report_mismatch(string what);
      if (mismatches < 200) begin
        $display("[%0t] mismatch: %s", $realtime, what);
      end
      mismatches++;
    endtask

    task check_hash(logic [WORD_W-1:0] got);
      logic [WORD_W-1:0] want;
      if (hashes_due.size() == 0) begin
        report_mismatch($sformatf("hash %h with none due", got));
      end else begin
        want = hashes_due.pop_front();
        if (got !== want) begin
          report_mismatch($sformatf("hash_value %h, want %h", got, want));
        end
      end
    endtask

    task check_drained();
      if (hashes_due.size() != 0) begin
        report_mismatch($sformatf("%0d hashes never arrived", hashes_due.size()));
      end
    endtask
  endclass

endpackage

>>> tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mh64_pkg::*;
  import mh64_tb_pkg::*;

  localparam int unsigned SETTLE      = 80;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned IDLE_PCT    = 34;

  logic              clk_i;
  logic              rst_ni       = 1'b0;
  logic              in_valid_i   = 1'b0;
  logic              in_stall_o;
  logic              first_word_i = 1'b0;
  logic [LEN_W-1:0]  key_length_i = '0;
  logic [WORD_W-1:0] data_word_i  = '0;
  logic              last_word_i  = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i  = 1'b0;
  logic [WORD_W-1:0] hash_value_o;
  logic              cfg_we_i     = 1'b0;
  logic [SEED_W-1:0] cfg_wdata_i  = '0;

  hash_board   board = new();
  int unsigned words_sent = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;

  murmur_hash_64a u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .first_word_i(first_word_i),
    .key_length_i(key_length_i),
    .data_word_i (data_word_i),
    .last_word_i (last_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .hash_value_o(hash_value_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      board.note_word(first_word_i, key_length_i, data_word_i, last_word_i);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_hash(hash_value_o);
    end
  end

  function automatic logic [WORD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [LEN_W-1:0] rand_len();
    return LEN_W'($urandom);
  endfunction

  // Offer one word, with random idle cycles ahead of it, and hold it until taken.
  task automatic send_word(input logic f, input logic [LEN_W-1:0] len,
                           input logic [WORD_W-1:0] data, input logic l);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    first_word_i <= f;
    key_length_i <= len;
    data_word_i  <= data;
    last_word_i  <= l;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
    calm = (words_sent >= 700 && words_sent < 850);
    if (words_sent == 300) hold_req = 1'b1;
  endtask

  // Well-formed key: word count follows the length.
  task automatic send_key(input logic [LEN_W-1:0] len);
    int unsigned nw;
    nw = (len == '0) ? 1 : (int'(len) + 7) / 8;
    for (int unsigned i = 0; i < nw; i++) begin
      send_word(i == 0, (i == 0) ? len : rand_len(), rand_word(), i == nw - 1);
    end
  endtask

  // Drain the block, then write the seed while it sits idle.
  task automatic load_seed(input logic [SEED_W-1:0] value);
    in_valid_i <= 1'b0;
    // let the monitor note the last accepted word first
    @(posedge clk_i);
    while (board.hashes_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    board.set_seed(value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned quota, input bit full_size);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned n;
    stop_at = words_sent + quota;
    if (full_size) send_key(MAX_KEY_BYTES);
    while (words_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        send_key(LEN_W'($urandom_range(48)));
      end else if (pick < 75) begin
        send_key(LEN_W'($urandom_range(256)));
      end else if (pick < 82) begin
        // stray word with no first word
        send_word(1'b0, rand_len(), rand_word(), 1'($urandom_range(1)));
      end else if (pick < 94) begin
        // any length, over the maximum too, with a word count that need not match
        n = $urandom_range(4, 1);
        for (int unsigned i = 0; i < n; i++) begin
          send_word(i == 0, rand_len(), rand_word(), i == n - 1);
        end
      end else begin
        // truncated key: the next first word cuts it off
        send_word(1'b1, LEN_W'($urandom_range(64, 9)), rand_word(), 1'b0);
      end
    end
  endtask

  initial begin : receiver
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        for (int unsigned c = 0; c < HOLD_CYCLES; c++) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // words before any first word run from a zero hash
    send_word(1'b0, '1, rand_word(), 1'b0);
    send_word(1'b0, '0, rand_word(), 1'b1);

    load_seed('1);
    send_word(1'b1, 13'd0, rand_word(), 1'b1);
    send_word(1'b1, 13'd1, '1, 1'b1);
    send_word(1'b1, 13'd7, '1, 1'b1);
    send_word(1'b1, 13'd8, '1, 1'b1);
    send_word(1'b1, 13'd13, '0, 1'b0);
    send_word(1'b0, '0, '1, 1'b1);
    send_word(1'b1, 13'd16, rand_word(), 1'b0);
    send_word(1'b0, '1, rand_word(), 1'b1);
    // length over the maximum, short word count
    send_word(1'b1, '1, '1, 1'b0);
    send_word(1'b0, '0, '0, 1'b1);
    send_word(1'b1, MAX_KEY_BYTES, rand_word(), 1'b1);
    send_word(1'b1, 13'd4097, '0, 1'b1);
    // words after the end continue from the finalized hash
    send_word(1'b0, rand_len(), rand_word(), 1'b0);
    send_word(1'b0, rand_len(), rand_word(), 1'b1);
    // new first word in the middle of a key restarts it
    send_word(1'b1, 13'd20, rand_word(), 1'b0);
    send_word(1'b1, 13'd3, rand_word(), 1'b1);

    load_seed('0);
    run_phase(185, 1'b0);
    load_seed(32'h0000_0001);
    run_phase(185, 1'b1);
    load_seed($urandom);
    run_phase(185, 1'b0);
    load_seed(32'h8000_0000);
    run_phase(185, 1'b0);
    load_seed('1);
    run_phase(185, 1'b0);

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.hashes_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    board.check_drained();
    if (board.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> murmur_hash_64a.f
rtl/core/mh64_pkg.sv
rtl/core/mh64_front.sv
rtl/core/mh64_fifo.sv
rtl/core/mh64_back.sv
rtl/core/murmur_hash_64a.sv
rtl/core/mh64_checker.sv
tb/sv/mh64_tb_pkg.sv
tb/sv/tb_top.sv
